[rtl/core/sdmd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdmd_pkg
// Types and constants shared by the schema-driven message deframer.
// ----------------------------------------------------------------------------
package sdmd_pkg;

    // Schema and message limits
    localparam int TYPE_COUNT = 256;
    localparam int MAX_FIELDS = 16;
    localparam int MSG_LIMIT  = 1024;

    localparam int TYPE_W   = $clog2(TYPE_COUNT);
    localparam int FLD_W    = $clog2(MAX_FIELDS);
    localparam int CADDR_W  = TYPE_W + FLD_W;
    localparam int CODE_DEPTH = TYPE_COUNT * MAX_FIELDS;

    // Input word kinds
    typedef enum logic [1:0] {
        K_BYTE  = 2'd0,
        K_CODE  = 2'd1,
        K_COUNT = 2'd2
    } t_kind;

    // Field layout codes
    typedef enum logic [2:0] {
        FC_INT8   = 3'd0,
        FC_INT16  = 3'd1,
        FC_INT32  = 3'd2,
        FC_FLOAT  = 3'd3,
        FC_DOUBLE = 3'd4,
        FC_STRING = 3'd5,
        FC_RAW    = 3'd6
    } t_fcode;

    // Input word
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] in_byte;
        logic [7:0] def_type;
        logic [3:0] def_index;
        logic [2:0] def_code;
        logic [4:0] def_count;
    } t_in_item;

    // Output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] out_type;
        logic [4:0] field_position;
        logic [9:0] byte_offset;
        logic       msg_end;
        logic       too_long;
    } t_out_item;

    // Counter setup for a newly entered field
    typedef struct packed {
        logic [15:0] left;
        logic        pfx;
    } t_load;

endpackage
`default_nettype wire

[rtl/core/schema_driven_message_deframer.sv]
`default_nettype none
// Path: an accepted stream byte is registered in stage B, then in the output register.
// Throughput: one word per cycle unless the output stalls; the schema code and count for
// the next field are read ahead from the schema memories, with write-first forwarding.
// Reset (sync, active low) clears parser state, the output stage and the count
// store's valid bits; the code store holds no defined value until written.
// ----------------------------------------------------------------------------
// schema_driven_message_deframer
// Splits a byte stream into typed messages using per-type field schemas held
// in two synchronous memories, and tags every stream byte.
// ----------------------------------------------------------------------------
module schema_driven_message_deframer (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  sdmd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output sdmd_pkg::t_out_item o_out_data
);
    import sdmd_pkg::*;

    // Schema memories
    logic [2:0]         r_code_mem [CODE_DEPTH];
    logic [4:0]         r_cnt_mem  [TYPE_COUNT];
    logic               r_cnt_vld  [TYPE_COUNT];

    logic [2:0]         r_code_rd;
    logic [4:0]         r_cnt_rd;
    logic               r_cnt_rd_v;

    // Stage B (processing) and output registers
    logic               r_b_valid;
    t_in_item           r_b_item;
    logic               r_o_valid;
    t_out_item          r_o_item;

    // Parser state
    logic               r_in_msg,   n_in_msg;
    logic [7:0]         r_cur_type, n_cur_type;
    logic [4:0]         r_fidx,     n_fidx;
    logic [15:0]        r_left,     n_left;
    logic               r_pfx,      n_pfx;
    logic [7:0]         r_len_lo,   n_len_lo;
    logic [9:0]         r_moff,     n_moff;

    logic               accept;
    logic               b_has_out;
    logic               b_fire;
    t_out_item          b_out;
    logic               adv;
    logic [4:0]         nidx;
    logic [4:0]         cnt;
    logic [10:0]        next_off;
    logic [15:0]        len;
    t_load              ld;

    logic               code_we;
    logic [CADDR_W-1:0] code_wa;
    logic [CADDR_W-1:0] code_ra;
    logic               cnt_we;
    logic [TYPE_W-1:0]  cnt_wa;
    logic [TYPE_W-1:0]  cnt_ra;
    logic [4:0]         cnt_wd;
    logic [4:0]         ra_idx;

    // Field code to counter setup
    function automatic t_load load_field(input logic [2:0] code);
        t_load r;
        r.pfx = 1'b0;
        case (code)
            FC_INT16:  r.left = 16'd2;
            FC_INT32:  r.left = 16'd4;
            FC_FLOAT:  r.left = 16'd4;
            FC_DOUBLE: r.left = 16'd8;
            FC_STRING: r.left = 16'd0;
            FC_RAW: begin
                r.left = 16'd2;
                r.pfx  = 1'b1;
            end
            default:   r.left = 16'd1;
        endcase
        return r;
    endfunction

    // Handshakes
    assign b_has_out  = r_b_valid && (r_b_item.kind == K_BYTE);
    assign b_fire     = r_b_valid && (!b_has_out || !r_o_valid || i_out_ready);
    assign o_in_ready = !r_b_valid || b_fire;
    assign accept     = i_in_valid && o_in_ready;

    assign cnt      = r_cnt_rd_v ? r_cnt_rd : 5'd0;
    assign nidx     = r_fidx + 5'd1;
    assign next_off = {1'b0, r_moff} + 11'd1;
    assign len      = {r_b_item.in_byte, r_len_lo};

    // Parse one stream byte
    always_comb begin
        n_in_msg   = r_in_msg;
        n_cur_type = r_cur_type;
        n_fidx     = r_fidx;
        n_left     = r_left;
        n_pfx      = r_pfx;
        n_len_lo   = r_len_lo;
        n_moff     = r_moff;
        adv        = 1'b0;
        ld         = load_field(r_code_rd);
        b_out.out_byte       = r_b_item.in_byte;
        b_out.out_type       = r_cur_type;
        b_out.field_position = 5'd0;
        b_out.byte_offset    = 10'd0;
        b_out.msg_end        = 1'b0;
        b_out.too_long       = 1'b0;

        if (b_fire && b_has_out) begin
            if (!r_in_msg) begin
                // type byte opens a message
                n_cur_type     = r_b_item.in_byte;
                b_out.out_type = r_b_item.in_byte;
                n_moff         = 10'd0;
                if (cnt == 5'd0) begin
                    b_out.msg_end = 1'b1;
                end else begin
                    n_in_msg = 1'b1;
                    n_fidx   = 5'd0;
                    n_left   = ld.left;
                    n_pfx    = ld.pfx;
                end
            end else begin
                // offset with saturation
                if (next_off >= 11'(MSG_LIMIT)) begin
                    b_out.byte_offset = 10'(MSG_LIMIT - 1);
                    b_out.too_long    = 1'b1;
                end else begin
                    b_out.byte_offset = next_off[9:0];
                end
                n_moff               = b_out.byte_offset;
                b_out.field_position = nidx;

                if (r_pfx) begin
                    if (r_left > 16'd1) begin
                        n_len_lo = r_b_item.in_byte;
                        n_left   = 16'd1;
                    end else begin
                        n_pfx  = 1'b0;
                        n_left = len;
                        adv    = (len == 16'd0);
                    end
                end else if (r_left != 16'd0) begin
                    n_left = r_left - 16'd1;
                    adv    = (r_left == 16'd1);
                end else begin
                    adv = (r_b_item.in_byte == 8'd0);
                end

                // step to next field or close the message
                if (adv) begin
                    n_fidx = nidx;
                    if (nidx >= cnt) begin
                        b_out.msg_end = 1'b1;
                        n_in_msg      = 1'b0;
                        n_left        = 16'd0;
                        n_pfx         = 1'b0;
                    end else begin
                        n_left = ld.left;
                        n_pfx  = ld.pfx;
                    end
                end
            end
        end
    end

    // Schema writes from stage B
    always_comb begin
        code_we = b_fire && (r_b_item.kind == K_CODE)
                  && (32'(r_b_item.def_type) < TYPE_COUNT)
                  && (32'(r_b_item.def_index) < MAX_FIELDS);
        code_wa = {r_b_item.def_type[TYPE_W-1:0], r_b_item.def_index[FLD_W-1:0]};
        cnt_we  = b_fire && (r_b_item.kind == K_COUNT)
                  && (32'(r_b_item.def_type) < TYPE_COUNT);
        cnt_wa  = r_b_item.def_type[TYPE_W-1:0];
        cnt_wd  = (32'(r_b_item.def_count) > MAX_FIELDS) ? 5'(MAX_FIELDS)
                                                         : r_b_item.def_count;
    end

    // Read-ahead addresses from the state the accepted word will see
    always_comb begin
        ra_idx = n_fidx + 5'd1;
        if (n_in_msg) begin
            code_ra = {n_cur_type[TYPE_W-1:0], ra_idx[FLD_W-1:0]};
            cnt_ra  = n_cur_type[TYPE_W-1:0];
        end else begin
            code_ra = {i_in_data.in_byte[TYPE_W-1:0], FLD_W'(0)};
            cnt_ra  = i_in_data.in_byte[TYPE_W-1:0];
        end
    end

    // Code store, write-first
    always_ff @(posedge i_clk) begin
        if (code_we) begin
            r_code_mem[code_wa] <= r_b_item.def_code;
        end
        if (accept) begin
            r_code_rd <= (code_we && code_wa == code_ra) ? r_b_item.def_code
                                                         : r_code_mem[code_ra];
        end
    end

    // Count store data, write-first
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (accept) begin
            r_cnt_rd <= (cnt_we && cnt_wa == cnt_ra) ? cnt_wd : r_cnt_mem[cnt_ra];
        end
    end

    // Count store valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TYPE_COUNT; i++) begin
                r_cnt_vld[i] <= 1'b0;
            end
            r_cnt_rd_v <= 1'b0;
        end else begin
            if (cnt_we) begin
                r_cnt_vld[cnt_wa] <= 1'b1;
            end
            if (accept) begin
                r_cnt_rd_v <= (cnt_we && cnt_wa == cnt_ra) ? 1'b1 : r_cnt_vld[cnt_ra];
            end
        end
    end

    // Stage B word register and output data register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_item <= i_in_data;
        end
        if (b_fire && b_has_out) begin
            r_o_item <= b_out;
        end
    end

    // Control and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_in_msg   <= 1'b0;
            r_cur_type <= 8'd0;
            r_fidx     <= 5'd0;
            r_left     <= 16'd0;
            r_pfx      <= 1'b0;
            r_len_lo   <= 8'd0;
            r_moff     <= 10'd0;
        end else begin
            r_b_valid  <= accept || (r_b_valid && !b_fire);
            r_o_valid  <= (b_fire && b_has_out) || (r_o_valid && !i_out_ready);
            r_in_msg   <= n_in_msg;
            r_cur_type <= n_cur_type;
            r_fidx     <= n_fidx;
            r_left     <= n_left;
            r_pfx      <= n_pfx;
            r_len_lo   <= n_len_lo;
            r_moff     <= n_moff;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_item;

endmodule
`default_nettype wire
